// ===== src/support_follow_action_sequencer_core_macros.svh =====
// Assertion helpers for the sequencer core.
`ifndef SUPPORT_FOLLOW_ACTION_SEQUENCER_CORE_MACROS_SVH
`define SUPPORT_FOLLOW_ACTION_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFAS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfas assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfas assertion failed");

`endif

// ===== src/sfas_pkg.sv =====
`default_nettype none

package sfas_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SPRAY   = 3'd1;
    localparam logic [2:0] CMD_PUSH    = 3'd2;
    localparam logic [2:0] CMD_ADVANCE = 3'd3;
    localparam logic [2:0] CMD_ABORT   = 3'd4;

    // report action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SPRAY   = 2'd1;
    localparam logic [1:0] ACT_PUSH    = 2'd2;
    localparam logic [1:0] ACT_ADVANCE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_PUSH_MAX    = 2'd0;
    localparam logic [1:0] REG_COLUMN      = 2'd1;
    localparam logic [1:0] REG_ADVANCE_MAX = 2'd2;
    localparam logic [1:0] REG_DEVICE_ID   = 2'd3;

    localparam logic [7:0] PUSH_MAX_RST    = 8'd70;
    localparam logic [7:0] COLUMN_RST      = 8'd20;
    localparam logic [7:0] ADVANCE_MAX_RST = 8'd70;
    localparam logic [7:0] DEVICE_ID_RST   = 8'd0;

    typedef struct packed {
        logic [7:0] push_max_ticks;
        logic [7:0] column_ticks;
        logic [7:0] advance_max_ticks;
        logic [7:0] device_id;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] amount;
        logic [15:0] sensor_distance;
    } item_t;

    typedef struct packed {
        logic [2:0] drive_phase;
        logic       report_valid;
        logic [1:0] report_action;
        logic       report_state;
        logic [7:0] report_device;
        logic       busy_res;
    } result_t;

endpackage

`default_nettype wire

// ===== src/sfas_cfg.sv =====
`default_nettype none

module sfas_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_wdata,
    output sfas_pkg::cfg_t     cfg
);

    sfas_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.push_max_ticks    <= sfas_pkg::PUSH_MAX_RST;
            cfg_reg.column_ticks      <= sfas_pkg::COLUMN_RST;
            cfg_reg.advance_max_ticks <= sfas_pkg::ADVANCE_MAX_RST;
            cfg_reg.device_id         <= sfas_pkg::DEVICE_ID_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfas_pkg::REG_PUSH_MAX:    cfg_reg.push_max_ticks    <= cfg_wdata;
                sfas_pkg::REG_COLUMN:      cfg_reg.column_ticks      <= cfg_wdata;
                sfas_pkg::REG_ADVANCE_MAX: cfg_reg.advance_max_ticks <= cfg_wdata;
                sfas_pkg::REG_DEVICE_ID:   cfg_reg.device_id         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/sfas_seq.sv =====
`default_nettype none

`include "support_follow_action_sequencer_core_macros.svh"

module sfas_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire sfas_pkg::item_t item,
    input  wire sfas_pkg::cfg_t  cfg,
    output sfas_pkg::result_t    res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SPRAY = 3'd1,
        PH_PUSH  = 3'd2,
        PH_DOWN  = 3'd3,
        PH_ADV   = 3'd4,
        PH_UP    = 3'd5
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [11:0] tick_reg,   tick_next;
    logic [11:0] limit_reg,  limit_next;
    logic [15:0] target_reg, target_next;

    logic        idle;
    logic [11:0] tick_inc;
    logic        done;
    logic [11:0] spray_len;
    logic        rpt_valid;
    logic [1:0]  rpt_action;
    logic        rpt_state;

    assign idle     = (phase_reg == PH_IDLE);
    assign tick_inc = tick_reg + 12'd1;
    assign done     = (tick_inc >= limit_reg);
    // low byte times ten: x*8 + x*2
    assign spray_len = {1'b0, item.amount[7:0], 3'b000}
                     + {3'b000, item.amount[7:0], 1'b0};

    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        limit_next  = limit_reg;
        target_next = target_reg;
        rpt_valid   = 1'b0;
        rpt_action  = sfas_pkg::ACT_NONE;
        rpt_state   = 1'b0;

        case (item.command)
            sfas_pkg::CMD_SPRAY: begin
                if (idle) begin
                    rpt_valid  = 1'b1;
                    rpt_action = sfas_pkg::ACT_SPRAY;
                    rpt_state  = 1'b1;
                    if (spray_len != 12'd0) begin
                        phase_next = PH_SPRAY;
                        tick_next  = 12'd0;
                        limit_next = spray_len;
                    end
                end
            end
            sfas_pkg::CMD_PUSH: begin
                if (idle) begin
                    rpt_valid   = 1'b1;
                    rpt_action  = sfas_pkg::ACT_PUSH;
                    rpt_state   = 1'b1;
                    target_next = item.sensor_distance + item.amount;
                    phase_next  = PH_PUSH;
                    tick_next   = 12'd0;
                    limit_next  = {4'd0, cfg.push_max_ticks};
                end
            end
            sfas_pkg::CMD_ADVANCE: begin
                if (idle) begin
                    rpt_valid   = 1'b1;
                    rpt_action  = sfas_pkg::ACT_ADVANCE;
                    rpt_state   = 1'b1;
                    target_next = item.amount;
                    phase_next  = PH_DOWN;
                    tick_next   = 12'd0;
                    limit_next  = {4'd0, cfg.column_ticks};
                end
            end
            sfas_pkg::CMD_ABORT: begin
                if (!idle) begin
                    // spray ends silently, column phases report as advance
                    if (phase_reg == PH_PUSH) begin
                        rpt_valid  = 1'b1;
                        rpt_action = sfas_pkg::ACT_PUSH;
                    end else if (phase_reg != PH_SPRAY) begin
                        rpt_valid  = 1'b1;
                        rpt_action = sfas_pkg::ACT_ADVANCE;
                    end
                    phase_next = PH_IDLE;
                    tick_next  = 12'd0;
                    limit_next = 12'd0;
                end
            end
            sfas_pkg::CMD_TICK: begin
                if (!idle) begin
                    tick_next = tick_inc;
                    case (phase_reg)
                        PH_SPRAY: begin
                            if (done) begin
                                phase_next = PH_IDLE;
                                tick_next  = 12'd0;
                                limit_next = 12'd0;
                            end
                        end
                        PH_PUSH: begin
                            if (done || item.sensor_distance >= target_reg) begin
                                rpt_valid  = 1'b1;
                                rpt_action = sfas_pkg::ACT_PUSH;
                                phase_next = PH_IDLE;
                                tick_next  = 12'd0;
                                limit_next = 12'd0;
                            end
                        end
                        PH_DOWN: begin
                            if (done) begin
                                phase_next = PH_ADV;
                                tick_next  = 12'd0;
                                limit_next = {4'd0, cfg.advance_max_ticks};
                            end
                        end
                        PH_ADV: begin
                            if (done || item.sensor_distance <= target_reg) begin
                                phase_next = PH_UP;
                                tick_next  = 12'd0;
                                limit_next = {4'd0, cfg.column_ticks};
                            end
                        end
                        PH_UP: begin
                            if (done) begin
                                rpt_valid  = 1'b1;
                                rpt_action = sfas_pkg::ACT_ADVANCE;
                                phase_next = PH_IDLE;
                                tick_next  = 12'd0;
                                limit_next = 12'd0;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            tick_next  = 12'd0;
                            limit_next = 12'd0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= 12'd0;
            limit_reg  <= 12'd0;
            target_reg <= 16'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            limit_reg  <= limit_next;
            target_reg <= target_next;
        end
    end

    always_comb begin
        res.drive_phase   = phase_next;
        res.report_valid  = rpt_valid;
        res.report_action = rpt_action;
        res.report_state  = rpt_state;
        res.report_device = rpt_valid ? cfg.device_id : 8'd0;
        res.busy_res      = (phase_next != PH_IDLE);
    end

    // counter never passes the loaded limit
    `SFAS_ASSERT_IMPL(a_tick_in_limit, aclk, aresetn, 1'b1, tick_reg <= limit_reg)
    // idle state carries cleared counters
    `SFAS_ASSERT_IMPL(a_idle_clear, aclk, aresetn, phase_reg == PH_IDLE,
        tick_reg == 12'd0 && limit_reg == 12'd0)
    // spray only ever returns to idle
    `SFAS_ASSERT_NEXT(a_spray_exit, aclk, aresetn, fire && phase_reg == PH_SPRAY,
        phase_reg == PH_SPRAY || phase_reg == PH_IDLE)
    // leaving column up always reports the end of the advance
    `SFAS_ASSERT_IMPL(a_up_report, aclk, aresetn,
        fire && phase_reg == PH_UP && phase_next == PH_IDLE,
        rpt_valid && rpt_action == sfas_pkg::ACT_ADVANCE && !rpt_state)

endmodule

`default_nettype wire

// ===== src/support_follow_action_sequencer_core.sv =====
// Hydraulic support valve sequencer.
// Input channel (s_valid/s_ready): one transaction per command: tick, start
// spray, start push, start advance or abort, with amount and sensor reading.
// Output channel (m_valid/m_ready): exactly one result per input transaction,
// in order: valve phase driven, optional start/end report, busy flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one of the four 8-bit
// registers, selected by cfg_index; write only while no transaction is in flight.
// Path: an accepted input is held in the input register, then the sequencer
// step writes its result into the result register, which drives m_valid.
// Throughput: one transaction per cycle while the output is not stalled; a single
// sequencer step sits between the input register and the result register.
// Stall: when m_ready is low the result register holds, the input register
// fills, and s_ready then drops until the output drains.
// Reset (aresetn low, synchronous): both stages empty, sequencer idle,
// registers back to push 70, column 20, advance 70, device 0.
`default_nettype none

module support_follow_action_sequencer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [15:0] s_amount,
    input  wire logic [15:0] s_sensor_distance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_drive_phase,
    output logic             m_report_valid,
    output logic [1:0]       m_report_action,
    output logic             m_report_state,
    output logic [7:0]       m_report_device,
    output logic             m_busy_res,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    sfas_pkg::cfg_t    cfg;
    sfas_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    sfas_pkg::result_t step_res;
    sfas_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command         <= s_command;
            in_item_reg.amount          <= s_amount;
            in_item_reg.sensor_distance <= s_sensor_distance;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    sfas_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfas_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign m_valid         = out_valid_reg;
    assign m_drive_phase   = out_res_reg.drive_phase;
    assign m_report_valid  = out_res_reg.report_valid;
    assign m_report_action = out_res_reg.report_action;
    assign m_report_state  = out_res_reg.report_state;
    assign m_report_device = out_res_reg.report_device;
    assign m_busy_res      = out_res_reg.busy_res;

endmodule

`default_nettype wire
